// ===== rtl/ac3p_pkg.sv =====
// Shared types, constants and lookup tables of the AC-3 / E-AC-3 header parser.
`default_nettype none
package ac3p_pkg;

  localparam int unsigned InDataW   = 88;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned OutUserW  = 2;
  localparam int unsigned ProdW     = 28;
  localparam int unsigned QuotW     = 23;
  localparam int unsigned RecipW    = 24;
  localparam int unsigned MulW      = QuotW + RecipW;
  localparam int unsigned RecipShift = 25;

  localparam logic [15:0] SYNC_WORD      = 16'h0B77;
  localparam logic [15:0] MIN_LENGTH     = 16'd9;
  localparam logic [4:0]  BSID_AC3_MAX   = 5'd10;
  localparam logic [4:0]  BSID_MAX       = 5'd16;
  localparam logic [4:0]  BSID_SHIFT_BASE = 5'd8;
  localparam logic [1:0]  FSCOD_48K      = 2'd0;
  localparam logic [1:0]  FSCOD_44K1     = 2'd1;
  localparam logic [1:0]  FSCOD_32K      = 2'd2;
  localparam logic [1:0]  FSCOD_RESERVED = 2'd3;
  localparam logic [5:0]  FRMSIZECOD_MAX = 6'd37;
  localparam logic [1:0]  FTYPE_RESERVED = 2'd3;
  localparam logic [10:0] FRMSIZ_MIN     = 11'd3;
  localparam logic [1:0]  BLOCKS_1       = 2'd0;
  localparam logic [1:0]  BLOCKS_2       = 2'd1;
  localparam logic [1:0]  BLOCKS_3       = 2'd2;
  localparam logic [1:0]  BLOCKS_6       = 2'd3;
  localparam logic [2:0]  ACMOD_1_0      = 3'd1;
  localparam logic [2:0]  ACMOD_2_0      = 3'd2;
  // ceil(2^25 / 3): exact division by three for any quotient input below 2^25.
  localparam logic [RecipW-1:0] RECIP3   = 24'hAAAAAB;

  typedef struct packed {
    logic             accepted;
    logic             enhanced;
    logic             div2;
    logic             div3;
    logic [15:0]      sample_rate;
    logic [QuotW-1:0] bit_rate;
    logic [2:0]       channel_count;
    logic [12:0]      frame_bytes;
  } ac3p_hdr_t;

  function automatic logic [15:0] ac3p_rate(input logic [1:0] code);
    logic [15:0] r;
    case (code)
      FSCOD_48K:  r = 16'd48000;
      FSCOD_44K1: r = 16'd44100;
      FSCOD_32K:  r = 16'd32000;
      default:    r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] ac3p_kbps(input logic [4:0] idx);
    logic [9:0] k;
    case (idx)
      5'd0:  k = 10'd32;
      5'd1:  k = 10'd40;
      5'd2:  k = 10'd48;
      5'd3:  k = 10'd56;
      5'd4:  k = 10'd64;
      5'd5:  k = 10'd80;
      5'd6:  k = 10'd96;
      5'd7:  k = 10'd112;
      5'd8:  k = 10'd128;
      5'd9:  k = 10'd160;
      5'd10: k = 10'd192;
      5'd11: k = 10'd224;
      5'd12: k = 10'd256;
      5'd13: k = 10'd320;
      5'd14: k = 10'd384;
      5'd15: k = 10'd448;
      5'd16: k = 10'd512;
      5'd17: k = 10'd576;
      5'd18: k = 10'd640;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  // 16-bit words per frame at 44.1 kHz for the even size codes; odd codes add one.
  function automatic logic [10:0] ac3p_words441(input logic [4:0] idx);
    logic [10:0] w;
    case (idx)
      5'd0:  w = 11'd69;
      5'd1:  w = 11'd87;
      5'd2:  w = 11'd104;
      5'd3:  w = 11'd121;
      5'd4:  w = 11'd139;
      5'd5:  w = 11'd174;
      5'd6:  w = 11'd208;
      5'd7:  w = 11'd243;
      5'd8:  w = 11'd278;
      5'd9:  w = 11'd348;
      5'd10: w = 11'd417;
      5'd11: w = 11'd487;
      5'd12: w = 11'd557;
      5'd13: w = 11'd696;
      5'd14: w = 11'd835;
      5'd15: w = 11'd975;
      5'd16: w = 11'd1114;
      5'd17: w = 11'd1253;
      5'd18: w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] ac3p_chan(input logic [2:0] acmod);
    logic [2:0] c;
    case (acmod)
      3'd0:    c = 3'd2;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd4;
      3'd6:    c = 3'd4;
      3'd7:    c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ac3p_decode.sv =====
// First pipeline stage: field extraction, validity checks and table lookups.
`default_nettype none
module ac3p_decode (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ac3p_pkg::InDataW-1:0]   in_data,
  output logic                                dec_valid,
  input  wire logic                           dec_ready,
  output ac3p_pkg::ac3p_hdr_t                 dec_hdr
);
  import ac3p_pkg::*;

  logic        valid_r, valid_nxt;
  ac3p_hdr_t   hdr_r, hdr_nxt;
  logic        take;

  logic [15:0] len;
  logic [15:0] sync;
  logic [55:0] hb;
  logic [4:0]  bsid;
  logic [1:0]  fscod;
  logic [5:0]  fsc;
  logic [2:0]  acmod;
  logic        lfe;
  logic [9:0]  kbps;
  logic [19:0] bps;
  logic [1:0]  sh;
  logic [1:0]  ftype;
  logic [10:0] frmsiz;
  logic [1:0]  code2;
  logic [15:0] half_rate;
  logic [2:0]  acmod_e;
  logic        lfe_e;
  logic        hdr_ok;

  always_comb begin
    len    = in_data[15:0];
    sync   = in_data[31:16];
    hb     = in_data[87:32];
    bsid   = hb[31:27];
    fscod  = hb[39:38];
    fsc    = hb[37:32];
    acmod  = hb[23:21];
    kbps   = ac3p_kbps(fsc[5:1]);
    bps    = 20'(kbps) * 20'd1000;
    sh     = (bsid > BSID_SHIFT_BASE) ? 2'(bsid - BSID_SHIFT_BASE) : 2'd0;
    ftype  = hb[55:54];
    frmsiz = hb[50:40];
    code2  = hb[37:36];
    acmod_e = hb[35:33];
    lfe_e  = hb[32];
    half_rate = ac3p_rate(code2) >> 1;

    // The LFE flag follows the optional mix-level fields of the AC-3 BSI.
    if (acmod == ACMOD_2_0) begin
      lfe = hb[18];
    end else if (acmod[0] && (acmod != ACMOD_1_0) && acmod[2]) begin
      lfe = hb[16];
    end else if ((acmod[0] && (acmod != ACMOD_1_0)) || acmod[2]) begin
      lfe = hb[18];
    end else begin
      lfe = hb[20];
    end

    hdr_ok  = (len >= MIN_LENGTH) && (sync == SYNC_WORD) && (bsid <= BSID_MAX);
    hdr_nxt = '0;
    if (hdr_ok && (bsid <= BSID_AC3_MAX)) begin
      if ((fscod != FSCOD_RESERVED) && (fsc <= FRMSIZECOD_MAX)) begin
        hdr_nxt.accepted      = 1'b1;
        hdr_nxt.sample_rate   = ac3p_rate(fscod) >> sh;
        hdr_nxt.bit_rate      = QuotW'(bps >> sh);
        hdr_nxt.channel_count = ac3p_chan(acmod) + 3'(lfe);
        case (fscod)
          FSCOD_48K:  hdr_nxt.frame_bytes = 13'(kbps) << 2;
          FSCOD_44K1: hdr_nxt.frame_bytes =
                        13'(ac3p_words441(fsc[5:1]) + 11'(fsc[0])) << 1;
          default:    hdr_nxt.frame_bytes = 13'(kbps) * 13'd6;
        endcase
      end
    end else if (hdr_ok) begin
      if ((ftype != FTYPE_RESERVED) && (frmsiz >= FRMSIZ_MIN) &&
          !((fscod == FSCOD_RESERVED) && (code2 == FSCOD_RESERVED))) begin
        hdr_nxt.accepted      = 1'b1;
        hdr_nxt.enhanced      = 1'b1;
        hdr_nxt.frame_bytes   = (13'(frmsiz) + 13'd1) << 1;
        hdr_nxt.channel_count = ac3p_chan(acmod_e) + 3'(lfe_e);
        if (fscod == FSCOD_RESERVED) begin
          // Half-rate stream: always six blocks per frame.
          hdr_nxt.sample_rate = half_rate;
          hdr_nxt.div2        = 1'b1;
          hdr_nxt.div3        = 1'b1;
        end else begin
          hdr_nxt.sample_rate = ac3p_rate(fscod);
          hdr_nxt.div2        = (code2 == BLOCKS_2) || (code2 == BLOCKS_6);
          hdr_nxt.div3        = (code2 == BLOCKS_3) || (code2 == BLOCKS_6);
        end
      end
    end
  end

  assign in_ready  = !valid_r || dec_ready;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take ? 1'b1 : (valid_r && !dec_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r <= hdr_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_hdr   = hdr_r;

endmodule
`default_nettype wire

// ===== rtl/ac3p_bitrate.sv =====
// Second and third pipeline stages: E-AC-3 rate product, block shift and divide by three.
`default_nettype none
module ac3p_bitrate (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          dec_valid,
  output logic                               dec_ready,
  input  wire ac3p_pkg::ac3p_hdr_t           dec_hdr,
  output logic                               br_valid,
  input  wire logic                          br_ready,
  output ac3p_pkg::ac3p_hdr_t                br_hdr,
  output logic [ac3p_pkg::MulW-1:0]          br_mul
);
  import ac3p_pkg::*;

  logic             v2_r, v2_nxt;
  ac3p_hdr_t        h2_r;
  logic [ProdW-1:0] prod2_r;
  logic             v3_r, v3_nxt;
  ac3p_hdr_t        h3_r, h3_nxt;
  logic [MulW-1:0]  mul3_r;
  logic             ready2, ready3, take2, take3;
  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  // Frame bytes times sample rate stays below 2^28.
  assign prod = ProdW'(29'(dec_hdr.frame_bytes) * 29'(dec_hdr.sample_rate));

  always_comb begin
    quot = h2_r.div2 ? QuotW'(prod2_r >> 6) : QuotW'(prod2_r >> 5);
    h3_nxt = h2_r;
    if (h2_r.enhanced) begin
      h3_nxt.bit_rate = quot;
    end
  end

  assign ready3    = !v3_r || br_ready;
  assign ready2    = !v2_r || ready3;
  assign take2     = dec_valid && ready2;
  assign take3     = v2_r && ready3;
  assign dec_ready = ready2;
  assign v2_nxt    = take2 ? 1'b1 : (v2_r && !ready3);
  assign v3_nxt    = take3 ? 1'b1 : (v3_r && !br_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      h2_r    <= dec_hdr;
      prod2_r <= prod;
    end
    if (take3) begin
      h3_r   <= h3_nxt;
      mul3_r <= MulW'(quot) * MulW'(RECIP3);
    end
  end

  assign br_valid = v3_r;
  assign br_hdr   = h3_r;
  assign br_mul   = mul3_r;

endmodule
`default_nettype wire

// ===== rtl/ac3_eac3_header_parser.sv =====
// Top level of the AC-3 / E-AC-3 sync-frame header parser with its output register.
// The input channel carries one sync-frame header per request: the buffer length,
// the big-endian sync word and the 56 header bits that follow it, first bit highest.
// The output channel returns exactly one result per request, in order: tuser holds
// the accepted and enhanced flags, tdata the sample rate, bit rate, channel count
// and frame size. A rejected header still yields a result, with every field zero.
// The parser is a four-stage pipeline: field decode and table lookups, the E-AC-3
// frame-size times sample-rate product, the block-count shift with a reciprocal
// multiply for division by three, and the output register that selects the result.
// An accepted request passes the decode, product, shift and output registers in turn;
// throughput is one header per cycle as long as the receiver keeps out_tready high.
// Each stage holds its own valid bit and advances when the next stage is free, so
// while the receiver holds out_tready low the earlier stages keep filling their
// empty slots, and in_tready drops only once all four stages hold a result.
// Nothing is lost or repeated on a stall. The synchronous reset clears the valid
// bits only; there is no other kept state and no setup after reset.
`default_nettype none
module ac3_eac3_header_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // header_length [15:0], sync_word [31:16], header_bits [87:32]
  input  wire logic [ac3p_pkg::InDataW-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // sample_rate [15:0], bit_rate [38:16], channel_count [41:39],
  // frame_bytes [54:42], zero [55]
  output logic [ac3p_pkg::OutDataW-1:0]        out_tdata,
  // accepted [0], enhanced [1]
  output logic [ac3p_pkg::OutUserW-1:0]        out_tuser
);
  import ac3p_pkg::*;

  logic            dec_valid, dec_ready;
  ac3p_hdr_t       dec_hdr;
  logic            br_valid, br_ready;
  ac3p_hdr_t       br_hdr;
  logic [MulW-1:0] br_mul;

  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic [OutUserW-1:0] out_user_r, out_user_nxt;
  logic [QuotW-1:0]    bit_rate;
  logic                take;

  ac3p_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_hdr   (dec_hdr)
  );

  ac3p_bitrate u_bitrate (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_hdr   (dec_hdr),
    .br_valid  (br_valid),
    .br_ready  (br_ready),
    .br_hdr    (br_hdr),
    .br_mul    (br_mul)
  );

  // For three or six blocks the shifted quotient still needs a division by three,
  // which the reciprocal product delivers in its upper bits.
  always_comb begin
    if (br_hdr.enhanced && br_hdr.div3) begin
      bit_rate = QuotW'(br_mul >> RecipShift);
    end else begin
      bit_rate = br_hdr.bit_rate;
    end
    out_data_nxt = {1'b0, br_hdr.frame_bytes, br_hdr.channel_count, bit_rate,
                    br_hdr.sample_rate};
    out_user_nxt = {br_hdr.enhanced, br_hdr.accepted};
  end

  assign br_ready      = !out_valid_r || out_tready;
  assign take          = br_valid && br_ready;
  assign out_valid_nxt = take ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  // A rejected header leaves every field zero.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("rejected header with nonzero fields");

  // An accepted header always has a sample rate, a frame size and a channel.
  a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[15:0] != 16'd0 && out_tdata[54:42] != 13'd0 &&
       out_tdata[41:39] != 3'd0))
    else $error("accepted header with empty fields");

  // Plain AC-3 bit rates never exceed 640 kbit/s.
  a_ac3_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && !out_tuser[1]) |->
      (out_tdata[38:16] <= 23'd640000))
    else $error("AC-3 bit rate out of range");

  // The divide-by-three path only ever serves E-AC-3 headers.
  a_div3_enh: assert property (@(posedge clk) disable iff (!rst_n)
    (br_valid && br_hdr.div3) |-> br_hdr.enhanced)
    else $error("block divider set on a non-enhanced header");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/ac3p_header_checker.sv =====
// Watches both channels of the header parser, predicts every result and compares it.
module ac3p_header_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [ac3p_pkg::InDataW-1:0]  in_tdata,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [ac3p_pkg::OutDataW-1:0] out_tdata,
  input  wire logic [ac3p_pkg::OutUserW-1:0] out_tuser,
  output int unsigned                        headers_in_flight,
  output int unsigned                        mismatch_count
);
  import ac3p_pkg::*;

  // Bit positions inside the 56 header bits, counted from the first bit sent.
  localparam int unsigned FTYPE_POS      = 0;
  localparam int unsigned FRMSIZ_POS     = 5;
  localparam int unsigned FSCOD_POS      = 16;
  localparam int unsigned FRMSIZECOD_POS = 18;
  localparam int unsigned FSCOD2_POS     = 18;
  localparam int unsigned ACMOD_E_POS    = 20;
  localparam int unsigned LFE_E_POS      = 23;
  localparam int unsigned BSID_POS       = 24;
  localparam int unsigned ACMOD_POS      = 32;
  localparam int unsigned MIXLEV_POS     = 35;
  localparam int unsigned PRINT_LIMIT    = 200;

  typedef struct packed {
    logic        accepted;
    logic        enhanced;
    logic [15:0] sample_rate;
    logic [22:0] bit_rate;
    logic [2:0]  channel_count;
    logic [12:0] frame_bytes;
  } header_info_t;

  header_info_t expected_info[$];
  header_info_t want;
  header_info_t got;
  int unsigned  result_index = 0;

  function automatic int unsigned hdr_field(input logic [55:0] hb, input int unsigned pos,
                                            input int unsigned width);
    logic [55:0] shifted;
    shifted = hb >> (56 - pos - width);
    return 32'(shifted & ((56'd1 << width) - 56'd1));
  endfunction

  function automatic int unsigned base_rate(input logic [1:0] code);
    case (code)
      FSCOD_48K:  return 48000;
      FSCOD_44K1: return 44100;
      FSCOD_32K:  return 32000;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned nominal_kbps(input logic [4:0] step);
    case (step)
      0: return 32;   1: return 40;   2: return 48;   3: return 56;
      4: return 64;   5: return 80;   6: return 96;   7: return 112;
      8: return 128;  9: return 160;  10: return 192; 11: return 224;
      12: return 256; 13: return 320; 14: return 384; 15: return 448;
      16: return 512; 17: return 576; 18: return 640;
      default: return 0;
    endcase
  endfunction

  // At 44.1 kHz the frame length is not a whole multiple of the rate, so odd
  // size codes carry one padding word on top of these.
  function automatic int unsigned frame_words(input logic [5:0] fsc, input logic [1:0] fscod);
    int unsigned kbps;
    kbps = nominal_kbps(fsc[5:1]);
    case (fscod)
      FSCOD_48K: return kbps * 2;
      FSCOD_32K: return kbps * 3;
      default: begin
        case (fsc[5:1])
          0: return 69 + fsc[0];    1: return 87 + fsc[0];    2: return 104 + fsc[0];
          3: return 121 + fsc[0];   4: return 139 + fsc[0];   5: return 174 + fsc[0];
          6: return 208 + fsc[0];   7: return 243 + fsc[0];   8: return 278 + fsc[0];
          9: return 348 + fsc[0];   10: return 417 + fsc[0];  11: return 487 + fsc[0];
          12: return 557 + fsc[0];  13: return 696 + fsc[0];  14: return 835 + fsc[0];
          15: return 975 + fsc[0];  16: return 1114 + fsc[0]; 17: return 1253 + fsc[0];
          default: return 1393 + fsc[0];
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned speakers(input logic [2:0] acmod);
    case (acmod)
      3'd0: return 2;
      3'd1: return 1;
      3'd2: return 2;
      3'd3, 3'd4: return 3;
      3'd5, 3'd6: return 4;
      default: return 5;
    endcase
  endfunction

  function automatic int unsigned block_count(input logic [1:0] code);
    case (code)
      BLOCKS_1: return 1;
      BLOCKS_2: return 2;
      BLOCKS_3: return 3;
      default:  return 6;
    endcase
  endfunction

  function automatic header_info_t decode_header(input logic [15:0] length,
                                                 input logic [15:0] sync,
                                                 input logic [55:0] hb);
    header_info_t    info;
    logic [4:0]      bsid;
    logic [1:0]      fscod;
    logic [5:0]      fsc;
    logic [2:0]      acmod;
    logic [1:0]      ftype;
    logic [1:0]      code2;
    logic [10:0]     frmsiz;
    int unsigned     lfe_pos;
    int unsigned     shift;
    int unsigned     rate;
    int unsigned     blocks;
    longint unsigned size;
    info = '0;
    bsid = 5'(hdr_field(hb, BSID_POS, 5));
    fscod = 2'(hdr_field(hb, FSCOD_POS, 2));
    if (length < MIN_LENGTH || sync != SYNC_WORD || bsid > BSID_MAX) return info;
    if (bsid <= BSID_AC3_MAX) begin
      fsc = 6'(hdr_field(hb, FRMSIZECOD_POS, 6));
      acmod = 3'(hdr_field(hb, ACMOD_POS, 3));
      if (fscod == FSCOD_RESERVED || fsc > FRMSIZECOD_MAX) return info;
      shift = (bsid > BSID_SHIFT_BASE) ? 32'(bsid - BSID_SHIFT_BASE) : 0;
      // The mix-level fields that precede lfeon exist only for some modes.
      lfe_pos = MIXLEV_POS;
      if (acmod == ACMOD_2_0) begin
        lfe_pos += 2;
      end else begin
        if (acmod[0] && acmod != ACMOD_1_0) lfe_pos += 2;
        if (acmod[2]) lfe_pos += 2;
      end
      info.accepted = 1'b1;
      info.sample_rate = 16'(base_rate(fscod) >> shift);
      info.bit_rate = 23'((nominal_kbps(fsc[5:1]) * 1000) >> shift);
      info.channel_count = 3'(speakers(acmod) + hdr_field(hb, lfe_pos, 1));
      info.frame_bytes = 13'(frame_words(fsc, fscod) * 2);
    end else begin
      ftype = 2'(hdr_field(hb, FTYPE_POS, 2));
      frmsiz = 11'(hdr_field(hb, FRMSIZ_POS, 11));
      code2 = 2'(hdr_field(hb, FSCOD2_POS, 2));
      if (ftype == FTYPE_RESERVED || frmsiz < FRMSIZ_MIN) return info;
      if (fscod == FSCOD_RESERVED) begin
        if (code2 == FSCOD_RESERVED) return info;
        rate = base_rate(code2) / 2;
        blocks = 6;
      end else begin
        rate = base_rate(fscod);
        blocks = block_count(code2);
      end
      size = 64'((longint'(frmsiz) + 1) * 2);
      info.accepted = 1'b1;
      info.enhanced = 1'b1;
      info.sample_rate = 16'(rate);
      info.frame_bytes = 13'(size);
      info.bit_rate = 23'((size * 64'(rate)) / 64'(blocks * 32));
      info.channel_count = 3'(speakers(3'(hdr_field(hb, ACMOD_E_POS, 3))) +
                              hdr_field(hb, LFE_E_POS, 1));
    end
    return info;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned expected_val,
                                 input longint unsigned actual_val);
    if (mismatch_count < PRINT_LIMIT)
      $display("header check: result %0d %s expected %0d got %0d", result_index, what,
               expected_val, actual_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_info.push_back(decode_header(in_tdata[15:0], in_tdata[31:16], in_tdata[87:32]));
      if (out_tvalid && out_tready) begin
        got.accepted = out_tuser[0];
        got.enhanced = out_tuser[1];
        got.sample_rate = out_tdata[15:0];
        got.bit_rate = out_tdata[38:16];
        got.channel_count = out_tdata[41:39];
        got.frame_bytes = out_tdata[54:42];
        if (expected_info.size() == 0) begin
          report_mismatch("arrived with no request outstanding, accepted", 64'd0,
                          64'(got.accepted));
        end else begin
          want = expected_info.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", 64'(want.accepted), 64'(got.accepted));
          if (got.enhanced !== want.enhanced)
            report_mismatch("enhanced", 64'(want.enhanced), 64'(got.enhanced));
          if (got.sample_rate !== want.sample_rate)
            report_mismatch("sample_rate", 64'(want.sample_rate), 64'(got.sample_rate));
          if (got.bit_rate !== want.bit_rate)
            report_mismatch("bit_rate", 64'(want.bit_rate), 64'(got.bit_rate));
          if (got.channel_count !== want.channel_count)
            report_mismatch("channel_count", 64'(want.channel_count),
                            64'(got.channel_count));
          if (got.frame_bytes !== want.frame_bytes)
            report_mismatch("frame_bytes", 64'(want.frame_bytes), 64'(got.frame_bytes));
        end
        result_index++;
      end
    end
    headers_in_flight <= 32'(expected_info.size());
  end

endmodule

// ===== tb/sv/ac3_eac3_header_parser_test.sv =====
// Stimulus and verdict for the AC-3 / E-AC-3 header parser, with the checker beside it.
module ac3_eac3_header_parser_test;
  import ac3p_pkg::*;

  // Header bit positions used to build requests, counted from the first bit sent.
  localparam int unsigned FTYPE_POS      = 0;
  localparam int unsigned FRMSIZ_POS     = 5;
  localparam int unsigned FSCOD_POS      = 16;
  localparam int unsigned FRMSIZECOD_POS = 18;
  localparam int unsigned FSCOD2_POS     = 18;
  localparam int unsigned BSID_POS       = 24;
  localparam int unsigned ACMOD_POS      = 32;
  localparam int unsigned PHASE_ITEMS    = 510;
  localparam int unsigned TAIL_CYCLES    = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // header_length [15:0], sync_word [31:16], header_bits [87:32]
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // sample_rate [15:0], bit_rate [38:16], channel_count [41:39],
  // frame_bytes [54:42], zero [55]
  logic [OutDataW-1:0] out_tdata;
  // accepted [0], enhanced [1]
  logic [OutUserW-1:0] out_tuser;

  int unsigned headers_in_flight;
  int unsigned mismatch_count;

  // Chance, in percent, that the sender idles before a request or that the
  // receiver holds out_tready low in a given cycle.
  int unsigned src_idle_pct = 25;
  int unsigned sink_stall_pct = 49;

  always #10 clk = ~clk;

  ac3_eac3_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ac3p_header_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .headers_in_flight (headers_in_flight),
    .mismatch_count    (mismatch_count)
  );

  // The receiver decides afresh every cycle whether it takes a result. With a
  // stall chance of zero it simply keeps out_tready high.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Random filler for the header bits; the fields that matter are overwritten.
  function automatic logic [55:0] random_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  function automatic logic [55:0] put_field(input logic [55:0] hb, input int unsigned pos,
                                            input int unsigned width, input logic [31:0] val);
    logic [55:0] mask;
    mask = ((56'd1 << width) - 56'd1) << (56 - pos - width);
    return (hb & ~mask) | ((56'(val) << (56 - pos - width)) & mask);
  endfunction

  // Plain AC-3 header with a chosen stream id, rate code, size code and
  // coding mode. Everything else, the LFE flag among it, stays random.
  function automatic logic [55:0] ac3_bits(input logic [4:0] bsid, input logic [1:0] fscod,
                                           input logic [5:0] fsc, input logic [2:0] acmod);
    logic [55:0] hb;
    hb = random_bits();
    hb = put_field(hb, BSID_POS, 5, 32'(bsid));
    hb = put_field(hb, FSCOD_POS, 2, 32'(fscod));
    hb = put_field(hb, FRMSIZECOD_POS, 6, 32'(fsc));
    return put_field(hb, ACMOD_POS, 3, 32'(acmod));
  endfunction

  // E-AC-3 header; code2 is the block-count code, or the half-rate code when
  // fscod is the reserved value.
  function automatic logic [55:0] eac3_bits(input logic [4:0] bsid, input logic [1:0] ftype,
                                            input logic [10:0] frmsiz, input logic [1:0] fscod,
                                            input logic [1:0] code2);
    logic [55:0] hb;
    hb = random_bits();
    hb = put_field(hb, BSID_POS, 5, 32'(bsid));
    hb = put_field(hb, FTYPE_POS, 2, 32'(ftype));
    hb = put_field(hb, FRMSIZ_POS, 11, 32'(frmsiz));
    hb = put_field(hb, FSCOD_POS, 2, 32'(fscod));
    return put_field(hb, FSCOD2_POS, 2, 32'(code2));
  endfunction

  // Offers one request and returns at the edge where the parser takes it.
  // Each cycle before the offer may be idle, so gaps land on every pipeline phase.
  task automatic offer_header(input logic [15:0] length, input logic [15:0] sync,
                              input logic [55:0] hb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hb, sync, length};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One random request. Most are well formed with random content so that
  // the decode paths get exercised; the rest is raw noise.
  task automatic offer_random_header();
    int unsigned pick;
    logic [1:0]  fscod;
    logic [5:0]  fsc;
    logic [15:0] sync;
    pick = $urandom_range(99);
    if (pick < 40) begin
      fscod = ($urandom_range(9) == 0) ? FSCOD_RESERVED : 2'($urandom_range(2));
      fsc = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 38))
                                     : 6'($urandom_range(FRMSIZECOD_MAX));
      offer_header(16'($urandom_range(16'hFFFF, MIN_LENGTH)), SYNC_WORD,
                   ac3_bits(5'($urandom_range(BSID_AC3_MAX)), fscod, fsc,
                            3'($urandom_range(7))));
    end else if (pick < 80) begin
      offer_header(16'($urandom_range(16'hFFFF, MIN_LENGTH)), SYNC_WORD,
                   eac3_bits(5'($urandom_range(BSID_MAX, BSID_AC3_MAX + 1)),
                             2'($urandom_range(3)), 11'($urandom_range(11'h7FF)),
                             2'($urandom_range(3)), 2'($urandom_range(3))));
    end else begin
      sync = ($urandom_range(1) == 0) ? SYNC_WORD : 16'($urandom);
      offer_header(16'($urandom_range(16'hFFFF)), sync, random_bits());
    end
  endtask

  task automatic wait_for_drain();
    // The checker's count is registered, so let it update before looking at it.
    @(posedge clk);
    while (headers_in_flight != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Every coding mode once, the shortest accepted buffer
    // first and the longest last.
    for (int a = 0; a < 8; a++) begin
      offer_header((a == 0) ? MIN_LENGTH : (a == 7) ? 16'hFFFF : 16'd100, SYNC_WORD,
                   ac3_bits(5'(a + 1), 2'(a % 3), 6'((a * 5) % 38), 3'(a)));
    end
    // Too short a buffer, an empty one, and a sync word off by one bit.
    offer_header(MIN_LENGTH - 16'd1, SYNC_WORD, ac3_bits(5'd8, FSCOD_48K, 6'd10, 3'd2));
    offer_header(16'd0, SYNC_WORD, ac3_bits(5'd8, FSCOD_48K, 6'd10, 3'd2));
    offer_header(16'd64, SYNC_WORD ^ 16'h8000, ac3_bits(5'd8, FSCOD_48K, 6'd10, 3'd2));
    // Stream id beyond every known version.
    offer_header(16'd64, SYNC_WORD, ac3_bits(BSID_MAX + 5'd1, FSCOD_48K, 6'd10, 3'd2));
    // Reserved AC-3 sample rate, and a size code one past the table.
    offer_header(16'd64, SYNC_WORD, ac3_bits(5'd6, FSCOD_RESERVED, 6'd10, 3'd7));
    offer_header(16'd64, SYNC_WORD, ac3_bits(5'd6, FSCOD_44K1, FRMSIZECOD_MAX + 6'd1, 3'd7));
    // The two reduced-rate AC-3 versions, at the ends of the size table.
    offer_header(16'd64, SYNC_WORD, ac3_bits(BSID_AC3_MAX, FSCOD_32K, FRMSIZECOD_MAX, 3'd3));
    offer_header(16'd64, SYNC_WORD, ac3_bits(BSID_SHIFT_BASE + 5'd1, FSCOD_44K1, 6'd0, 3'd0));
    // E-AC-3: reserved frame type, a frame too small, the smallest legal one.
    offer_header(16'd64, SYNC_WORD, eac3_bits(5'd11, FTYPE_RESERVED, 11'd100, FSCOD_48K, BLOCKS_6));
    offer_header(16'd64, SYNC_WORD,
                 eac3_bits(5'd11, 2'd0, FRMSIZ_MIN - 11'd1, FSCOD_48K, BLOCKS_6));
    offer_header(16'd64, SYNC_WORD, eac3_bits(5'd11, 2'd1, FRMSIZ_MIN, FSCOD_32K, BLOCKS_2));
    // Largest frame at the highest rate, at the top stream id.
    offer_header(16'd64, SYNC_WORD, eac3_bits(BSID_MAX, 2'd2, 11'h7FF, FSCOD_48K, BLOCKS_6));
    // Half-rate: reserved second code is rejected, a legal one halves the rate.
    offer_header(16'd64, SYNC_WORD,
                 eac3_bits(5'd12, 2'd0, 11'd500, FSCOD_RESERVED, FSCOD_RESERVED));
    offer_header(16'd64, SYNC_WORD, eac3_bits(5'd13, 2'd0, 11'd500, FSCOD_RESERVED, FSCOD_32K));
    // One block per frame, the smallest divisor.
    offer_header(16'd64, SYNC_WORD, eac3_bits(5'd14, 2'd0, 11'h7FF, FSCOD_48K, BLOCKS_1));

    // Hold the sender back until the pipeline has handed over every result.
    in_tvalid <= 1'b0;
    wait_for_drain();

    for (int i = 0; i < PHASE_ITEMS; i++) offer_random_header();
    src_idle_pct <= 49;
    sink_stall_pct <= 25;
    for (int i = 0; i < PHASE_ITEMS; i++) offer_random_header();
    src_idle_pct <= 0;
    sink_stall_pct <= 0;
    for (int i = 0; i < PHASE_ITEMS; i++) offer_random_header();

    in_tvalid <= 1'b0;
    wait_for_drain();
    // Wait on for TAIL_CYCLES so that a stray extra result would still be seen.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
